@@ rtl/sqlk_pkg.sv @@
package sqlk_pkg;

  // scan phases
  localparam logic [2:0] PH_SKIP       = 3'd0;
  localparam logic [2:0] PH_DASH       = 3'd1;
  localparam logic [2:0] PH_LINE       = 3'd2;
  localparam logic [2:0] PH_SLASH      = 3'd3;
  localparam logic [2:0] PH_BLOCK      = 3'd4;
  localparam logic [2:0] PH_BLOCK_STAR = 3'd5;
  localparam logic [2:0] PH_WORD       = 3'd6;
  localparam logic [2:0] PH_DONE       = 3'd7;

  // result classes
  localparam logic [1:0] CLASS_SELECT = 2'd0;
  localparam logic [1:0] CLASS_INSERT = 2'd1;
  localparam logic [1:0] CLASS_OTHER  = 2'd2;

  // ascii codes used by the scanner
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_UNDER   = 8'h5f;

  // keyword candidates; the last one is insert
  localparam int CAND_COUNT = 8;
  localparam int INSERT_IDX = 7;
  localparam int LEN_W      = 4;
  localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;

  localparam logic [63:0] CAND_TEXT [CAND_COUNT] = '{
    64'("select"), 64'("with"), 64'("show"), 64'("describe"),
    64'("desc"), 64'("explain"), 64'("exists"), 64'("insert")
  };
  localparam logic [LEN_W-1:0] CAND_LEN [CAND_COUNT] = '{
    4'd6, 4'd4, 4'd4, 4'd8, 4'd4, 4'd7, 4'd6, 4'd6
  };

  // depth of the queue between scanner and classifier
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // finished keyword summary handed to the back end
  typedef struct packed {
    logic [CAND_COUNT-1:0] mask;
    logic [LEN_W-1:0]      len;
  } kw_t;

  // character of candidate k at keyword position pos (pos below the length)
  function automatic logic [7:0] cand_char(input int k, input logic [LEN_W-1:0] pos);
    logic [LEN_W-1:0] idx;
    idx = CAND_LEN[k] - pos - 4'd1;
    return CAND_TEXT[k][{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/sqlk_scan.sv @@
module sqlk_scan
  import sqlk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_query,
  output logic       kw_push,
  output kw_t        kw_data
);

  logic [2:0]            phase, phase_next;
  logic [LEN_W-1:0]      len, len_next;
  logic [CAND_COUNT-1:0] mask, mask_next;
  logic                  is_ws, is_upper, is_word, add;
  logic [7:0]            low;
  logic [CAND_COUNT-1:0] letter_mask;

  // character classes
  assign is_ws    = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
  assign is_upper = (char_code >= 8'h41) && (char_code <= 8'h5a);
  assign is_word  = is_upper || ((char_code >= 8'h61) && (char_code <= 8'h7a)) ||
                    (char_code == CH_UNDER);
  assign low      = is_upper ? (char_code | 8'h20) : char_code;

  // candidates that survive one more letter
  always_comb begin
    for (int k = 0; k < CAND_COUNT; k++) begin
      letter_mask[k] = mask[k] && (len < CAND_LEN[k]) && (cand_char(k, len) == low);
    end
  end

  // phase machine
  always_comb begin
    phase_next = phase;
    add        = 1'b0;
    unique case (phase)
      PH_SKIP: begin
        if (is_ws) phase_next = PH_SKIP;
        else if (char_code == CH_DASH) phase_next = PH_DASH;
        else if (char_code == CH_SLASH) phase_next = PH_SLASH;
        else if (is_word) begin
          phase_next = PH_WORD;
          add        = 1'b1;
        end else phase_next = PH_DONE;
      end
      PH_DASH:  phase_next = (char_code == CH_DASH) ? PH_LINE : PH_DONE;
      PH_LINE:  phase_next = (char_code == CH_NEWLINE) ? PH_SKIP : PH_LINE;
      PH_SLASH: phase_next = (char_code == CH_STAR) ? PH_BLOCK : PH_DONE;
      PH_BLOCK: phase_next = (char_code == CH_STAR) ? PH_BLOCK_STAR : PH_BLOCK;
      PH_BLOCK_STAR: begin
        if (char_code == CH_SLASH) phase_next = PH_SKIP;
        else if (char_code != CH_STAR) phase_next = PH_BLOCK;
      end
      PH_WORD: begin
        if (is_word) add = 1'b1;
        else phase_next = PH_DONE;
      end
      PH_DONE:  phase_next = PH_DONE;
      default:  phase_next = PH_DONE;
    endcase
    mask_next = add ? letter_mask : mask;
    len_next  = (add && len != LEN_MAX) ? len + 4'd1 : len;
  end

  // keyword summary goes out with the last beat
  assign kw_push      = accept && end_of_query;
  assign kw_data.mask = mask_next;
  assign kw_data.len  = len_next;

  // scanner state, back to reset after each query
  always_ff @(posedge clk) begin
    if (rst || kw_push) begin
      phase <= PH_SKIP;
      len   <= '0;
      mask  <= '1;
    end else if (accept) begin
      phase <= phase_next;
      len   <= len_next;
      mask  <= mask_next;
    end
  end

  a_fresh_after_last: assert property (@(posedge clk) disable iff (rst)
    kw_push |=> (phase == PH_SKIP && len == '0 && mask == '1))
    else $error("scanner not cleared after last beat");

  a_len_only_in_word: assert property (@(posedge clk) disable iff (rst)
    (len != '0) |-> (phase == PH_WORD || phase == PH_DONE))
    else $error("keyword length outside word phase");

  a_mask_full_when_empty: assert property (@(posedge clk) disable iff (rst)
    (len == '0) |-> (mask == '1))
    else $error("candidate mask narrowed with no letters");

endmodule

@@ rtl/sqlk_fifo.sv @@
module sqlk_fifo
  import sqlk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  kw_t  wr_data,
  output logic full,
  input  logic rd_en,
  output logic not_empty,
  output kw_t  rd_data
);

  kw_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr, do_rd;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

endmodule

@@ rtl/sqlk_classify.sv @@
module sqlk_classify
  import sqlk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       kw_valid,
  input  kw_t        kw_data,
  output logic       kw_take,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] query_class
);

  logic       out_valid;
  logic [1:0] class_next;

  // first candidate whose full text was matched wins
  always_comb begin
    class_next = CLASS_OTHER;
    for (int k = CAND_COUNT - 1; k >= 0; k--) begin
      if (kw_data.mask[k] && kw_data.len == CAND_LEN[k])
        class_next = (k == INSERT_IDX) ? CLASS_INSERT : CLASS_SELECT;
    end
  end

  // output register refills while the current beat leaves
  assign kw_take = kw_valid && (!out_valid || pop);
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (kw_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (kw_take) query_class <= class_next;
  end

endmodule

@@ rtl/sql_statement_kind_classifier_core.sv @@
// statement kind classifier: query text in, one class per query out
// input queue side: char_code and end_of_query, one byte per beat, taken when
//   push is high and full is low; end_of_query marks the last byte
// result queue side: query_class is shown while empty is low and leaves on
//   a beat with pop high; 0 select-like, 1 insert, 2 other
// the front scanner updates its state in the cycle a byte is taken, so bytes
//   stream at one per cycle while full is low; on the last byte it hands the
//   keyword summary to a two-entry queue, and the back end turns it into the
//   class in the output register
// the result is registered first in the queue and then in the output
//   register, from which it can leave on a beat with pop high
// unless full: one byte per cycle, one query per cycle for one-byte queries
// full rises only when the queue is full and the output register is held, so
//   a stalled receiver blocks input only after two more queries have finished
// reset clears scanner state, queue fill count and output valid flag; no query in flight
module sql_statement_kind_classifier_core
  import sqlk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_query,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] query_class
);

  logic accept;
  logic kw_push, kw_valid, kw_take;
  kw_t  kw_in, kw_out;

  assign accept = push && !full;

  // front: byte scanner
  sqlk_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .end_of_query (end_of_query),
    .kw_push      (kw_push),
    .kw_data      (kw_in)
  );

  // queue between front and back
  sqlk_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (kw_push),
    .wr_data   (kw_in),
    .full      (full),
    .rd_en     (kw_take),
    .not_empty (kw_valid),
    .rd_data   (kw_out)
  );

  // back: classification and output register
  sqlk_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .kw_valid    (kw_valid),
    .kw_data     (kw_out),
    .kw_take     (kw_take),
    .pop         (pop),
    .empty       (empty),
    .query_class (query_class)
  );

endmodule
